### sv/pils_pkg.sv
package pils_pkg;

  localparam int NUM_IDS = 64;
  localparam int ID_W = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
  localparam int EVENT_ID_W = 6;
  localparam int STAMP_W = 64;
  localparam int COUNT_W = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int DIV_STEPS = STAMP_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  localparam logic [STAMP_W-1:0] ALL_ONES = {STAMP_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef struct packed {
    logic                command;
    logic                out_of_range;
    logic [ID_W-1:0]     slot;
    logic [STAMP_W-1:0]  elapsed;
  } item_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  count;
    logic [STAMP_W-1:0]  total;
    logic [STAMP_W-1:0]  shortest;
    logic [STAMP_W-1:0]  mean;
    logic [STAMP_W-1:0]  longest;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam entry_t ENTRY_RESET = '{count: '0, total: '0, shortest: ALL_ONES,
                                     mean: '0, longest: '0};

endpackage

### sv/pils_if.sv
interface pils_in_if;
  import pils_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  command;
  logic [EVENT_ID_W-1:0] event_id;
  logic [STAMP_W-1:0]    start_stamp;
  logic [STAMP_W-1:0]    end_stamp;

  modport source (output valid, command, event_id, start_stamp, end_stamp, input ready);
  modport sink (input valid, command, event_id, start_stamp, end_stamp, output ready);
endinterface

interface pils_out_if;
  import pils_pkg::*;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] event_count;
  logic [STAMP_W-1:0] total_elapsed;
  logic [STAMP_W-1:0] shortest_elapsed;
  logic [STAMP_W-1:0] mean_elapsed;
  logic [STAMP_W-1:0] longest_elapsed;

  modport source (output valid, event_count, total_elapsed, shortest_elapsed, mean_elapsed,
                  longest_elapsed, input ready);
  modport sink (input valid, event_count, total_elapsed, shortest_elapsed, mean_elapsed,
                longest_elapsed, output ready);
endinterface

### sv/pils_ram.sv
module pils_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### sv/pils_front.sv
module pils_front (
  input  logic               clk,
  input  logic               rst_n,
  pils_in_if.sink            in_chan,
  output logic               push_valid,
  input  logic               push_ready,
  output pils_pkg::item_t    push_item
);
  import pils_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign in_chan.ready = !valid_r || push_ready;
  assign push_valid = valid_r;
  assign push_item = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_chan.ready) begin
      valid_nxt = in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Elapsed time wraps modulo 2^64 when the stamps are out of order.
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      item_r.command      <= in_chan.command;
      item_r.out_of_range <= (32'(in_chan.event_id) >= 32'(NUM_IDS));
      item_r.slot         <= ID_W'(in_chan.event_id);
      item_r.elapsed      <= in_chan.end_stamp - in_chan.start_stamp;
    end
  end

endmodule

### sv/pils_queue.sv
module pils_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  pils_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output pils_pkg::item_t pop_item
);
  import pils_pkg::*;

  item_t             slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] fill_r, fill_nxt;
  logic              do_push, do_pop;

  assign push_ready = (fill_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_item   = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### sv/pils_div.sv
module pils_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [pils_pkg::STAMP_W-1:0] dividend,
  input  logic [pils_pkg::COUNT_W-1:0] divisor,
  output logic                         done,
  output logic [pils_pkg::STAMP_W-1:0] quotient
);
  import pils_pkg::*;

  logic [COUNT_W-1:0]   rem_r, rem_nxt;
  logic [STAMP_W-1:0]   quo_r, quo_nxt;
  logic [COUNT_W-1:0]   div_r;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 done_r, done_nxt;
  logic [COUNT_W:0]     trial;

  assign done = done_r;
  assign quotient = quo_r;

  // Restoring division, one quotient bit per cycle; the dividend shifts out
  // of the top of quo_r while quotient bits shift in at the bottom.
  always_comb begin
    trial    = {rem_r, quo_r[STAMP_W-1]};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      cnt_nxt = DIV_CNT_W'(DIV_STEPS);
    end else if (cnt_r != '0) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = COUNT_W'(trial - {1'b0, div_r});
        quo_nxt = {quo_r[STAMP_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[COUNT_W-1:0];
        quo_nxt = {quo_r[STAMP_W-2:0], 1'b0};
      end
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      div_r <= divisor;
    end
  end

endmodule

### sv/pils_back.sv
module pils_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  pils_pkg::item_t pop_item,
  pils_out_if.source      out_chan
);
  import pils_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;

  logic [2:0]         state_r, state_nxt;
  item_t              item_r;
  entry_t             entry_r, entry_nxt;
  logic [NUM_IDS-1:0] vld_r, vld_nxt;
  logic               out_valid_r, out_valid_nxt;
  entry_t             out_r;
  entry_t             shown;
  logic               load_out;

  logic               ram_we;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             cur, upd;
  logic               div_start, div_done;
  logic [STAMP_W-1:0] div_quo;
  logic               is_record;

  assign is_record = (item_r.command == CMD_RECORD) && !item_r.out_of_range;
  assign pop_ready = (state_r == S_IDLE);
  assign load_out  = (state_r == S_FIN) && (!out_valid_r || out_chan.ready);
  assign ram_we    = load_out && is_record;

  pils_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_IDS)) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (item_r.slot),
    .wr_data (entry_r),
    .rd_addr (pop_item.slot),
    .rd_data (ram_rdata)
  );

  pils_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (upd.total),
    .divisor  (upd.count),
    .done     (div_done),
    .quotient (div_quo)
  );

  // An entry never written reads as its reset contents.
  always_comb begin
    cur = vld_r[item_r.slot] ? entry_t'(ram_rdata) : ENTRY_RESET;
    upd = cur;
    if (cur.count != COUNT_MAX) begin
      upd.count = cur.count + 1'b1;
    end
    upd.total = cur.total + item_r.elapsed;
    if (item_r.elapsed < cur.shortest) begin
      upd.shortest = item_r.elapsed;
    end
    if (item_r.elapsed > cur.longest) begin
      upd.longest = item_r.elapsed;
    end
  end

  // The shortest time is shown as zero while the entry holds no record.
  always_comb begin
    shown = entry_r;
    if (entry_r.count == '0) begin
      shown.shortest = '0;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    entry_nxt     = entry_r;
    vld_nxt       = vld_r;
    out_valid_nxt = out_valid_r;
    div_start     = 1'b0;
    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (pop_valid) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (item_r.out_of_range) begin
          entry_nxt = '0;
          state_nxt = S_FIN;
        end else if (item_r.command == CMD_READ) begin
          entry_nxt = cur;
          state_nxt = S_FIN;
        end else begin
          entry_nxt = upd;
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          entry_nxt.mean = div_quo;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          if (is_record) begin
            vld_nxt[item_r.slot] = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (pop_valid && pop_ready) begin
      item_r <= pop_item;
    end
    if (load_out) begin
      out_r <= shown;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.event_count      = out_r.count;
  assign out_chan.total_elapsed    = out_r.total;
  assign out_chan.shortest_elapsed = out_r.shortest;
  assign out_chan.mean_elapsed     = out_r.mean;
  assign out_chan.longest_elapsed  = out_r.longest;

endmodule

### sv/per_id_latency_statistics.sv
// Channel    Role    Handshake     Payload
// in_chan    sink    valid/ready   command, event_id, start_stamp, end_stamp
// out_chan   source  valid/ready   event_count, total_elapsed, shortest_elapsed,
//                                  mean_elapsed, longest_elapsed
//
// With the back end idle, a read item goes from the queue head through the read
// and finish states to a registered result; a record item also passes the divide
// state, where the 64-step bit-serial divider forms the mean. An accepted item
// reaches the queue head via the front-stage register. The front stage and the
// two-item queue take items until full while the back end works or output stalls.
// Synchronous active-low reset empties the pipeline and marks every entry as
// unwritten, so the table needs no clearing pass.
module per_id_latency_statistics (
  input logic        clk,
  input logic        rst_n,
  pils_in_if.sink    in_chan,
  pils_out_if.source out_chan
);
  import pils_pkg::*;

  logic  push_valid, push_ready, pop_valid, pop_ready;
  item_t push_item, pop_item;

  pils_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  pils_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  pils_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_chan  (out_chan)
  );

endmodule

### sv/pils_checker.sv
module pils_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [pils_pkg::COUNT_W-1:0] event_count,
  input logic [pils_pkg::STAMP_W-1:0] total_elapsed,
  input logic [pils_pkg::STAMP_W-1:0] shortest_elapsed,
  input logic [pils_pkg::STAMP_W-1:0] mean_elapsed,
  input logic [pils_pkg::STAMP_W-1:0] longest_elapsed
);
  import pils_pkg::*;

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(total_elapsed) && $stable(event_count))
    else $error("result changed while stalled");

  a_empty_shortest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_count == '0 |-> shortest_elapsed == '0)
    else $error("shortest shown nonzero for an empty entry");

  a_empty_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_count == '0 |->
      total_elapsed == '0 && mean_elapsed == '0 && longest_elapsed == '0)
    else $error("empty entry carries statistics");

endmodule

bind per_id_latency_statistics pils_checker u_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .event_count      (out_chan.event_count),
  .total_elapsed    (out_chan.total_elapsed),
  .shortest_elapsed (out_chan.shortest_elapsed),
  .mean_elapsed     (out_chan.mean_elapsed),
  .longest_elapsed  (out_chan.longest_elapsed)
);
